[hw/rtl/lcdpw_pkg.sv]
// Shared types and constants of the LCD pixel write front end.
// No dependencies; all lcdpw_* modules and the top level use it by scoped names.
package lcdpw_pkg;

    localparam int PANEL_WIDTH   = 132;
    localparam int PANEL_HEIGHT  = 132;
    localparam int TABLE_ENTRIES = 48;
    localparam int TABLE_BANK    = TABLE_ENTRIES / 3;

    // bus regions (address high nibble)
    localparam logic [3:0] REGION_CMD  = 4'h0;
    localparam logic [3:0] REGION_DATA = 4'h4;

    // controller commands
    localparam logic [7:0] CMD_COLUMN = 8'h2a;
    localparam logic [7:0] CMD_ROW    = 8'h2b;
    localparam logic [7:0] CMD_RAMWR  = 8'h2c;
    localparam logic [7:0] CMD_LUT    = 8'h2d;
    localparam logic [7:0] CMD_ACCESS = 8'h36;
    localparam logic [7:0] CMD_MODE   = 8'h3a;

    // color modes
    localparam logic [2:0] MODE_8BIT   = 3'd2;
    localparam logic [2:0] MODE_12A    = 3'd3;
    localparam logic [2:0] MODE_12B    = 3'd4;
    localparam logic [2:0] MODE_16BIT  = 3'd5;
    localparam logic [2:0] MODE_24BIT  = 3'd6;
    localparam logic [2:0] MODE_24ALT  = 3'd7;

    localparam logic [7:0] WINDOW_END_RESET = 8'd131;
    localparam logic [2:0] LAST_PHASE       = 3'd5;

    // one processed bus write; strobes are qualified by the pipeline advancing
    typedef struct packed {
        logic       cmd_wr;
        logic       data_wr;
        logic [7:0] cmd;     // current command, seen by data writes
        logic [7:0] data;
        logic [5:0] count;
        logic [2:0] phase;
    } bus_op_t;

    // color decode result: number of pixel puts and their colors
    typedef struct packed {
        logic [1:0]  puts;
        logic [15:0] color0;
        logic [15:0] color1;
    } color_res_t;

    // panel coordinate of one put
    typedef struct packed {
        logic       on;
        logic [7:0] x;
        logic [7:0] y;
    } coord_t;

    typedef struct packed {
        logic        last;
        logic [15:0] color;
        logic [7:0]  y;
        logic [7:0]  x;
    } beat_t;

endpackage

[hw/rtl/lcdpw_color.sv]
// Color decode: mode register, pixel byte buffer and the three 16-entry lookup banks.
// Depends on lcdpw_pkg.
module lcdpw_color
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcdpw_pkg::bus_op_t    op,
    output lcdpw_pkg::color_res_t res
);

    logic [2:0]  mode_reg;
    logic [7:0]  buf0_reg;
    logic [7:0]  buf1_reg;
    logic [15:0] color_a_reg;
    logic [7:0]  red_lut_reg   [lcdpw_pkg::TABLE_BANK];
    logic [7:0]  green_lut_reg [lcdpw_pkg::TABLE_BANK];
    logic [7:0]  blue_lut_reg  [lcdpw_pkg::TABLE_BANK];

    logic        pix_wr;
    logic [1:0]  p3;
    logic        p2;
    logic [11:0] w12;
    logic [3:0]  ri;
    logic [3:0]  gi;
    logic [3:0]  bi;
    logic [15:0] lut_color;
    logic        buf0_wr;
    logic        buf1_wr;
    logic        color_a_wr;

    function automatic logic [15:0] compose(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        compose = {r[4:0], 11'b0} + {3'b0, g, 5'b0} + {8'b0, b};
    endfunction

    assign pix_wr = op.data_wr && (op.cmd == lcdpw_pkg::CMD_RAMWR);
    assign p2     = op.phase[0];
    assign p3     = (op.phase >= 3'd3) ? 2'(op.phase - 3'd3) : op.phase[1:0];

    // 12-bit word: first half of mode A at phase 1, otherwise the low 12 bits
    always_comb
    begin
        if (mode_reg == lcdpw_pkg::MODE_12A && p3 == 2'd1)
            w12 = {buf0_reg, op.data[7:4]};
        else if (mode_reg == lcdpw_pkg::MODE_12A)
            w12 = {buf1_reg[3:0], op.data};
        else
            w12 = {buf0_reg[3:0], op.data};
    end

    always_comb
    begin
        if (mode_reg == lcdpw_pkg::MODE_8BIT)
        begin
            ri = {1'b0, op.data[7:5]};
            gi = {1'b0, op.data[4:2]};
            bi = {2'b0, op.data[1:0]};
        end
        else
        begin
            ri = w12[11:8];
            gi = w12[7:4];
            bi = w12[3:0];
        end
    end

    assign lut_color = compose(red_lut_reg[ri], green_lut_reg[gi], blue_lut_reg[bi]);

    always_comb
    begin
        res        = '0;
        buf0_wr    = 1'b0;
        buf1_wr    = 1'b0;
        color_a_wr = 1'b0;
        if (pix_wr)
        begin
            case (mode_reg)
                lcdpw_pkg::MODE_8BIT:
                begin
                    res.puts   = 2'd1;
                    res.color0 = lut_color;
                end
                lcdpw_pkg::MODE_12A:
                begin
                    buf0_wr    = (p3 == 2'd0);
                    buf1_wr    = (p3 == 2'd1);
                    color_a_wr = (p3 == 2'd1);
                    if (p3 == 2'd2)
                    begin
                        res.puts   = 2'd2;
                        res.color0 = color_a_reg;
                        res.color1 = lut_color;
                    end
                end
                lcdpw_pkg::MODE_12B:
                begin
                    buf0_wr = !p2;
                    if (p2)
                    begin
                        res.puts   = 2'd1;
                        res.color0 = lut_color;
                    end
                end
                lcdpw_pkg::MODE_16BIT:
                begin
                    buf0_wr = !p2;
                    if (p2)
                    begin
                        res.puts   = 2'd1;
                        res.color0 = {buf0_reg, op.data};
                    end
                end
                lcdpw_pkg::MODE_24BIT, lcdpw_pkg::MODE_24ALT:
                begin
                    buf0_wr = (p3 == 2'd0);
                    buf1_wr = (p3 == 2'd1);
                    if (p3 == 2'd2)
                    begin
                        res.puts   = 2'd1;
                        res.color0 = compose({3'b0, buf0_reg[7:3]}, {2'b0, buf1_reg[7:2]},
                                             {3'b0, op.data[7:3]});
                    end
                end
                default:
                begin
                    res.puts = 2'd0;
                end
            endcase
        end
    end

    // payload: buffer and held color, no reset
    always_ff @(posedge clk)
    begin
        if (buf0_wr)
            buf0_reg <= op.data;
        if (buf1_wr)
            buf1_reg <= op.data;
        if (color_a_wr)
            color_a_reg <= lut_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lcdpw_pkg::MODE_16BIT;
            for (int i = 0; i < lcdpw_pkg::TABLE_BANK; i++)
            begin
                red_lut_reg[i]   <= 8'(i);
                green_lut_reg[i] <= 8'(2 * i);
                blue_lut_reg[i]  <= 8'(i);
            end
        end
        else if (op.data_wr)
        begin
            if (op.cmd == lcdpw_pkg::CMD_MODE)
                mode_reg <= op.data[2:0];
            if (op.cmd == lcdpw_pkg::CMD_LUT)
            begin
                case (op.count[5:4])
                    2'd0:    red_lut_reg[op.count[3:0]]   <= op.data;
                    2'd1:    green_lut_reg[op.count[3:0]] <= op.data;
                    2'd2:    blue_lut_reg[op.count[3:0]]  <= op.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[hw/rtl/lcdpw_pos.sv]
// Write position, window and memory access options; maps up to two puts to panel coordinates.
// Depends on lcdpw_pkg.
module lcdpw_pos
(
    input  logic               clk,
    input  logic               rst_n,
    input  lcdpw_pkg::bus_op_t op,
    input  logic [1:0]         puts,
    output lcdpw_pkg::coord_t  pos0,
    output lcdpw_pkg::coord_t  pos1
);

    localparam logic [8:0] X_MAX = 9'(lcdpw_pkg::PANEL_WIDTH - 1);
    localparam logic [8:0] Y_MAX = 9'(lcdpw_pkg::PANEL_HEIGHT - 1);

    logic [7:0] col_reg;
    logic [7:0] row_reg;
    logic [7:0] col_start_reg;
    logic [7:0] col_end_reg;
    logic [7:0] row_start_reg;
    logic [7:0] row_end_reg;
    logic       mirror_rows_reg;
    logic       mirror_cols_reg;
    logic       swap_reg;

    logic [7:0] col1;
    logic [7:0] row1;
    logic [7:0] col2;
    logic [7:0] row2;

    // one step of the raster walk, wrapping inside the window
    function automatic logic [15:0] step(input logic [7:0] c, input logic [7:0] r,
                                         input logic [7:0] cs, input logic [7:0] ce,
                                         input logic [7:0] rs, input logic [7:0] re);
        logic [8:0] nx;
        logic [8:0] ny;
        nx = {1'b0, c} + 9'd1;
        ny = {1'b0, r} + 9'd1;
        if (nx > {1'b0, ce})
            step = {cs, (ny > {1'b0, re}) ? rs : ny[7:0]};
        else
            step = {nx[7:0], r};
    endfunction

    function automatic lcdpw_pkg::coord_t map(input logic [7:0] c, input logic [7:0] r,
                                              input logic sw, input logic mc, input logic mr);
        logic [8:0] sx;
        logic [8:0] sy;
        logic [8:0] mx;
        logic [8:0] my;
        sx = {1'b0, sw ? r : c};
        sy = {1'b0, sw ? c : r};
        mx = X_MAX - sx;
        my = Y_MAX - sy;
        map.on = (sx <= X_MAX) && (sy <= Y_MAX);
        map.x  = mc ? mx[7:0] : sx[7:0];
        map.y  = mr ? my[7:0] : sy[7:0];
    endfunction

    assign {col1, row1} = step(col_reg, row_reg, col_start_reg, col_end_reg,
                               row_start_reg, row_end_reg);
    assign {col2, row2} = step(col1, row1, col_start_reg, col_end_reg,
                               row_start_reg, row_end_reg);

    assign pos0 = map(col_reg, row_reg, swap_reg, mirror_cols_reg, mirror_rows_reg);
    assign pos1 = map(col1, row1, swap_reg, mirror_cols_reg, mirror_rows_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            col_start_reg   <= '0;
            col_end_reg     <= lcdpw_pkg::WINDOW_END_RESET;
            row_start_reg   <= '0;
            row_end_reg     <= lcdpw_pkg::WINDOW_END_RESET;
            mirror_rows_reg <= 1'b0;
            mirror_cols_reg <= 1'b0;
            swap_reg        <= 1'b0;
        end
        else if (op.cmd_wr)
        begin
            if (op.data == lcdpw_pkg::CMD_RAMWR)
            begin
                col_reg <= col_start_reg;
                row_reg <= row_start_reg;
            end
        end
        else if (op.data_wr)
        begin
            case (op.cmd)
                lcdpw_pkg::CMD_COLUMN:
                begin
                    if (op.count == 6'd0)
                        col_start_reg <= op.data;
                    else
                        col_end_reg <= op.data;
                end
                lcdpw_pkg::CMD_ROW:
                begin
                    if (op.count == 6'd0)
                        row_start_reg <= op.data;
                    else
                        row_end_reg <= op.data;
                end
                lcdpw_pkg::CMD_ACCESS:
                begin
                    mirror_rows_reg <= op.data[7];
                    mirror_cols_reg <= op.data[6];
                    swap_reg        <= op.data[5];
                end
                default: ;
            endcase
            if (puts == 2'd1)
            begin
                col_reg <= col1;
                row_reg <= row1;
            end
            else if (puts == 2'd2)
            begin
                col_reg <= col2;
                row_reg <= row2;
            end
        end
    end

endmodule

[hw/rtl/lcdpw_obuf.sv]
// Two-slot result register feeding the pixel stream; loads up to two beats at once.
// Depends on lcdpw_pkg.
module lcdpw_obuf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [1:0]       load_cnt,
    input  lcdpw_pkg::beat_t beat0,
    input  lcdpw_pkg::beat_t beat1,
    input  logic             m_axis_tready,
    output logic             m_axis_tvalid,
    output lcdpw_pkg::beat_t head,
    output logic             room
);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    lcdpw_pkg::beat_t slot0_reg;
    lcdpw_pkg::beat_t slot1_reg;
    logic             pop;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign head          = slot0_reg;
    assign pop           = m_axis_tvalid && m_axis_tready;
    // room for two fresh beats once the head leaves
    assign room          = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_axis_tready);

    always_comb
    begin
        if (load)
            cnt_next = load_cnt;
        else if (pop)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= beat0;
            slot1_reg <= beat1;
        end
        else if (pop)
            slot0_reg <= slot1_reg;
    end

endmodule

[hw/rtl/lcd_controller_pixel_write.sv]
// Top level of the LCD controller pixel write front end: bus beat in, pixel writes out.
// Depends on lcdpw_pkg, lcdpw_color, lcdpw_pos and lcdpw_obuf.
//
//  channel  | dir | tdata                         | tuser            | tlast
//  ---------+-----+-------------------------------+------------------+-----------
//  s_axis   | in  | [7:0] data_byte               | [3:0] addr_region| -
//  m_axis   | out | [7:0] x, [15:8] y, [31:16] rgb| -                | last_pixel
//
// A bus beat is taken into an input register, decoded against the
// command/window/lookup state and its pixels (zero, one or two) are loaded into a
// two-slot result register. A beat giving one pixel or none retires every cycle
// while m_axis does not stall; a 12-bit mode A beat that gives two pixels holds off
// the next beat until the first of its pixels has left the single output port.
// Reset restores the default window, 16-bit mode and lookup table; a stall on
// m_axis holds the beats and backs up s_axis through the input register.
module lcd_controller_pixel_write
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [3:0]  s_axis_tuser,   // [3:0] addr_region
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [31:16] pixel_color
    output logic        m_axis_tlast    // last_pixel
);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [3:0] in_region_reg;
    logic [7:0] in_byte_reg;

    // command sequencing state
    logic [7:0] cmd_reg;
    logic [7:0] cmd_next;
    logic [5:0] count_reg;
    logic [5:0] count_next;
    logic [2:0] phase_reg;
    logic [2:0] phase_next;

    logic                  room;
    logic                  fire;
    logic                  accept;
    lcdpw_pkg::bus_op_t    op;
    lcdpw_pkg::color_res_t cres;
    lcdpw_pkg::coord_t     pos0;
    lcdpw_pkg::coord_t     pos1;
    lcdpw_pkg::beat_t      pix0;
    lcdpw_pkg::beat_t      pix1;
    lcdpw_pkg::beat_t      beat0;
    lcdpw_pkg::beat_t      head;
    logic                  on0;
    logic                  on1;
    logic [1:0]            load_cnt;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_region_reg <= s_axis_tuser;
            in_byte_reg   <= s_axis_tdata;
        end
    end

    // decoded operation, strobes only when the beat retires
    assign op.cmd_wr  = fire && (in_region_reg == lcdpw_pkg::REGION_CMD);
    assign op.data_wr = fire && (in_region_reg == lcdpw_pkg::REGION_DATA);
    assign op.cmd     = cmd_reg;
    assign op.data    = in_byte_reg;
    assign op.count   = count_reg;
    assign op.phase   = phase_reg;

    // command byte clears the counters; data beats bump them
    always_comb
    begin
        cmd_next   = cmd_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        if (op.cmd_wr)
        begin
            cmd_next   = in_byte_reg;
            count_next = '0;
            phase_next = '0;
        end
        else if (op.data_wr)
        begin
            if (count_reg < 6'(lcdpw_pkg::TABLE_ENTRIES))
                count_next = count_reg + 6'd1;
            phase_next = (phase_reg == lcdpw_pkg::LAST_PHASE) ? 3'd0 : phase_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= lcdpw_pkg::CMD_RAMWR;
            count_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            cmd_reg   <= cmd_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    lcdpw_color u_color
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .res   (cres)
    );

    lcdpw_pos u_pos
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .puts  (cres.puts),
        .pos0  (pos0),
        .pos1  (pos1)
    );

    // drop off-panel puts and pack the survivors; the later survivor carries last
    assign on0 = (cres.puts != 2'd0) && pos0.on;
    assign on1 = (cres.puts == 2'd2) && pos1.on;

    assign load_cnt = {1'b0, on0} + {1'b0, on1};

    assign pix0 = '{last: 1'b0, color: cres.color0, y: pos0.y, x: pos0.x};
    assign pix1 = '{last: 1'b1, color: cres.color1, y: pos1.y, x: pos1.x};

    always_comb
    begin
        beat0 = on0 ? pix0 : pix1;
        beat0.last = (load_cnt == 2'd1);
    end

    lcdpw_obuf u_obuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .load_cnt      (load_cnt),
        .beat0         (beat0),
        .beat1         (pix1),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .head          (head),
        .room          (room)
    );

    assign m_axis_tdata = {head.color, head.y, head.x};
    assign m_axis_tlast = head.last;

endmodule
